// ===== hdl/drnm_pkg.sv =====
// ----------------------------------------------------------------------------
// drnm_pkg
// Types and fixed-point constants for the delta-R nearest-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package drnm_pkg;

  // Item codes on the kind field
  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_CAND  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_SQ_ETA,
    S_SQ_PHI,
    S_CMP,
    S_ROOT,
    S_EMIT
  } state_t;

  localparam int IN_W    = 16;  // coordinate port width
  localparam int COORD_W = 17;  // internal coordinate, holds sign or unsigned 16-bit
  localparam int DIFF_W  = 18;  // difference of two coordinates
  localparam int MAG_W   = 17;  // magnitude of a difference
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SQ_W    = 36;  // squared distance, Q.24
  localparam int ROOT_W  = 18;  // floor(sqrt) of a SQ_W value
  localparam int DIST_W  = 17;
  localparam int INDEX_W = 7;

  // pi and 2*pi in Q3.12
  localparam logic signed [DIFF_W-1:0] PI_Q     = 18'sd12868;
  localparam logic signed [DIFF_W-1:0] NEG_PI_Q = -18'sd12868;
  localparam logic signed [DIFF_W-1:0] TWO_PI_Q = 18'sd25736;

  localparam logic [DIST_W-1:0]  DIST_SAT    = '1;
  localparam logic [INDEX_W-1:0] INDEX_NONE  = '1;  // -1
  localparam logic [SQ_W-1:0]    SQUARE_ONES = '1;

endpackage

`default_nettype wire

// ===== hdl/delta_r_nearest_match.sv =====
// ----------------------------------------------------------------------------
// delta_r_nearest_match
// Nearest candidate to a reference object in eta-phi space.
// ----------------------------------------------------------------------------
// A begin item (kind 0) loads the reference eta/phi and opens a new candidate
// set. Each candidate item (kind 1) forms deta = ref_eta - eta and
// dphi = ref_phi - phi, wraps dphi into [-pi, pi] one 2*pi step per cycle,
// squares both on one shared 17x17 multiplier and keeps the smallest sum and
// its position; ties keep the earlier candidate. Candidates past
// MAX_CANDIDATES are dropped and set the overflowed flag. An end item (kind 2)
// returns one result item: nearest_index, best_distance = floor(sqrt(sum)) in
// unsigned Q5.12 and found; an empty set gives index -1, distance 131071 and
// found 0. The end item then clears the set but keeps the reference. Kind 3
// is ignored. Coordinates are Q3.12.
// Sequence: a begin item is handled in the idle state alone. A candidate
// passes accept, the wrap check (repeated for each 2*pi correction of dphi),
// two squarings on the shared multiplier and the compare. An end item runs an
// 18-iteration digit-by-digit square root for a non-empty set, skips it for an
// empty one, and then waits for the output register to drain. The block takes
// one item at a time (in_ready is high only while idle); candidates may still
// be taken while a result waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_r_nearest_match
  import drnm_pkg::*;
#(
  parameter int MAX_CANDIDATES = 64,
  parameter int COORD_WIDTH    = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          kind,
  input  wire logic signed [15:0]  eta,
  input  wire logic signed [15:0]  phi,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [INDEX_W-1:0] nearest_index,
  output logic [DIST_W-1:0]        best_distance,
  output logic                     found,
  output logic                     overflowed
);

  localparam int CNT_W    = $clog2(MAX_CANDIDATES + 1);
  localparam int SIGN_POS = (COORD_WIDTH > IN_W) ? IN_W - 1 : COORD_WIDTH - 1;
  localparam bit USE_SIGN = (COORD_WIDTH <= IN_W);

  // Low COORD_WIDTH bits, sign extended; wider settings read the port unsigned
  function automatic logic signed [COORD_W-1:0] coord_ext(input logic [IN_W-1:0] raw);
    logic [COORD_W-1:0] ext;
    for (int i = 0; i < IN_W; i++) begin
      ext[i] = (i <= SIGN_POS) ? raw[i] : (USE_SIGN ? raw[SIGN_POS] : 1'b0);
    end
    ext[COORD_W-1] = USE_SIGN ? raw[SIGN_POS] : 1'b0;
    return signed'(ext);
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] a;
    a = v[DIFF_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  state_t state, state_next;

  logic signed [COORD_W-1:0] ref_eta, ref_phi;
  logic [SQ_W-1:0]           best_square;
  logic [CNT_W-1:0]          best_slot;
  logic [CNT_W-1:0]          seen_count;
  logic                      overflow_flag;

  logic signed [DIFF_W-1:0]  deta, dphi;
  logic [PROD_W-1:0]         prod;
  logic [SQ_W-1:0]           sum;
  logic [SQ_W-1:0]           rem, root, bitv;

  // Combinational helpers
  logic                      in_fire, set_full, set_empty, load_out;
  logic                      wrap_hi, wrap_lo;
  logic [MAG_W-1:0]          mul_a;
  logic [PROD_W-1:0]         mul_p;
  logic [SQ_W-1:0]           sq_total;
  logic [SQ_W-1:0]           trial;
  logic                      take;
  logic signed [COORD_W-1:0] eta_c, phi_c;
  logic [31:0]               slot_wide;
  logic [DIST_W-1:0]         dist_val;

  assign eta_c     = coord_ext(eta);
  assign phi_c     = coord_ext(phi);
  assign in_fire   = in_valid && in_ready;
  assign set_full  = (seen_count == CNT_W'(MAX_CANDIDATES));
  assign set_empty = (seen_count == '0);
  assign wrap_hi   = (dphi > PI_Q);
  assign wrap_lo   = (dphi < NEG_PI_Q);

  // Shared multiplier: deta magnitude first, then dphi
  assign mul_a     = (state == S_SQ_ETA) ? mag(deta) : mag(dphi);
  assign mul_p     = PROD_W'(mul_a) * PROD_W'(mul_a);
  assign sq_total  = sum + SQ_W'(prod);

  // Square root step
  assign trial     = root + bitv;
  assign take      = (rem >= trial);

  assign slot_wide = 32'(best_slot);
  assign dist_val  = root[ROOT_W-1] ? DIST_SAT : root[DIST_W-1:0];

  // Outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_EMIT: load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (kind_t'(kind))
            KIND_CAND: state_next = set_full ? S_IDLE : S_WRAP;
            KIND_END:  state_next = set_empty ? S_EMIT : S_ROOT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_WRAP:   if (!wrap_hi && !wrap_lo) state_next = S_SQ_ETA;
      S_SQ_ETA: state_next = S_SQ_PHI;
      S_SQ_PHI: state_next = S_CMP;
      S_CMP:    state_next = S_IDLE;
      S_ROOT:   if (bitv[0]) state_next = S_EMIT;
      S_EMIT:   if (load_out) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state and set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      ref_eta       <= '0;
      ref_phi       <= '0;
      best_square   <= SQUARE_ONES;
      best_slot     <= '0;
      seen_count    <= '0;
      overflow_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (in_fire && kind_t'(kind) == KIND_BEGIN) begin
        ref_eta       <= eta_c;
        ref_phi       <= phi_c;
        best_square   <= SQUARE_ONES;
        seen_count    <= '0;
        overflow_flag <= 1'b0;
      end
      if (in_fire && kind_t'(kind) == KIND_CAND && set_full) overflow_flag <= 1'b1;

      if (state == S_CMP) begin
        if (sq_total < best_square) begin
          best_square <= sq_total;
          best_slot   <= seen_count;
        end
        seen_count <= seen_count + CNT_W'(1);
      end

      // End of set: clear bookkeeping once the result is latched
      if (load_out) begin
        best_square   <= SQUARE_ONES;
        seen_count    <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // Datapath: differences, squares, square root, result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      deta <= DIFF_W'(ref_eta) - DIFF_W'(eta_c);
      dphi <= DIFF_W'(ref_phi) - DIFF_W'(phi_c);
      rem  <= best_square;
      root <= '0;
      bitv <= SQ_W'(1) << (SQ_W - 2);
    end

    if (state == S_WRAP) begin
      if (wrap_hi)      dphi <= dphi - TWO_PI_Q;
      else if (wrap_lo) dphi <= dphi + TWO_PI_Q;
    end

    if (state == S_SQ_ETA) prod <= mul_p;
    if (state == S_SQ_PHI) begin
      sum  <= SQ_W'(prod);
      prod <= mul_p;
    end

    if (state == S_ROOT) begin
      if (take) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end

    if (load_out) begin
      overflowed <= overflow_flag;
      if (set_empty) begin
        nearest_index <= INDEX_NONE;
        best_distance <= DIST_SAT;
        found         <= 1'b0;
      end else begin
        nearest_index <= slot_wide[INDEX_W-1:0];
        best_distance <= dist_val;
        found         <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
